/* design/decimal_text_to_int64_saturating_top_macros.svh */
// assertion macros for the decimal text to int64 converter
`ifndef DECIMAL_TEXT_TO_INT64_SATURATING_TOP_MACROS_SVH
`define DECIMAL_TEXT_TO_INT64_SATURATING_TOP_MACROS_SVH

// checked only out of reset
`define DTOI_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked at every edge, reset included
`define DTOI_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* design/dtoi_pkg.sv */
// shared types and constants for the decimal text to int64 converter
package dtoi_pkg;

  localparam logic [63:0] POS_LIMIT = 64'h7fff_ffff_ffff_ffff;
  localparam logic [63:0] NEG_LIMIT = 64'h8000_0000_0000_0000;

  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_PLUS  = 8'h2b;
  localparam logic [7:0] CHAR_MINUS = 8'h2d;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_SAT_HIGH = 2'd1,
    ST_SAT_LOW  = 2'd2,
    ST_NAN      = 2'd3
  } status_t;

  typedef struct packed {
    logic       last_char;
    logic [7:0] character;
  } item_t;

  typedef struct packed {
    logic [63:0] value;
    status_t     status;
  } result_t;

endpackage

/* design/decimal_text_to_int64_saturating_top.sv */
// decimal text to saturating int64 converter, top level
// path: input register, combinational digit step, output register
// throughput: one character per cycle while no result is held, back-to-back texts too
// the input register and the one-pass digit step (ten times plus digit) set that rate
// a held result stalls only the last character of the next text, not the ones before it
// reset (rst, synchronous) empties both registers and returns the parser to leading spaces
module decimal_text_to_int64_saturating_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] character
  input  logic        s_axis_tlast,   // last_char
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata,   // [63:0] value
  output logic [1:0]  m_axis_tuser    // [1:0] status
);

  logic              item_valid;
  dtoi_pkg::item_t   item;
  dtoi_pkg::result_t result;
  logic              out_free;
  logic              step;

  assign out_free = !m_axis_tvalid || m_axis_tready;
  assign step     = item_valid && (!item.last_char || out_free);

  dtoi_in_reg u_in_reg (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .take          (step),
    .item_valid    (item_valid),
    .item          (item)
  );

  dtoi_core u_core (
    .clk    (clk),
    .rst    (rst),
    .step   (step),
    .item   (item),
    .result (result)
  );

  dtoi_out_reg u_out_reg (
    .clk           (clk),
    .rst           (rst),
    .load          (step && item.last_char),
    .result        (result),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

endmodule

/* design/dtoi_in_reg.sv */
// input register stage for incoming characters
module dtoi_in_reg (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  logic [7:0]        s_axis_tdata,   // [7:0] character
  input  logic              s_axis_tlast,   // last_char
  input  logic              take,
  output logic              item_valid,
  output dtoi_pkg::item_t   item
);

  assign s_axis_tready = !item_valid || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (s_axis_tvalid && s_axis_tready) begin
      item_valid <= 1'b1;
    end else if (take) begin
      item_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      item.character <= s_axis_tdata;
      item.last_char <= s_axis_tlast;
    end
  end

endmodule

/* design/dtoi_core.sv */
// parse state and digit accumulation, one character per step
module dtoi_core (
  input  logic              clk,
  input  logic              rst,
  input  logic              step,
  input  dtoi_pkg::item_t   item,
  output dtoi_pkg::result_t result
);

  typedef enum logic [1:0] {
    PH_SPACES  = 2'd0,
    PH_SIGNED  = 2'd1,
    PH_DIGITS  = 2'd2,
    PH_STOPPED = 2'd3
  } phase_t;

  phase_t      phase, phase_next;
  logic        negative, negative_next;
  logic [63:0] magnitude, magnitude_next;
  logic [63:0] neg_magnitude, neg_magnitude_next;   // two's complement of magnitude
  logic        too_large, too_large_next;
  logic        digit_seen, digit_seen_next;

  logic        is_digit;
  logic        take_digit;
  logic [3:0]  digit;
  logic [67:0] scaled;
  logic [63:0] neg_scaled;
  logic        overflow;

  assign is_digit = (item.character >= dtoi_pkg::CHAR_ZERO) &&
                    (item.character <= dtoi_pkg::CHAR_NINE);
  assign digit    = 4'(item.character - dtoi_pkg::CHAR_ZERO);

  // ten times magnitude plus digit, with headroom to see the 2^63 cap
  assign scaled     = {1'b0, magnitude, 3'b000} + {3'b000, magnitude, 1'b0} + {64'd0, digit};
  assign neg_scaled = {neg_magnitude[60:0], 3'b000} + {neg_magnitude[62:0], 1'b0}
                      - {60'd0, digit};
  assign overflow   = scaled > {4'd0, dtoi_pkg::NEG_LIMIT};

  always_comb begin
    phase_next = phase;
    negative_next = negative;
    take_digit = 1'b0;
    unique case (phase)
      PH_SPACES: begin
        if (item.character == dtoi_pkg::CHAR_SPACE) begin
          phase_next = PH_SPACES;
        end else if (item.character == dtoi_pkg::CHAR_PLUS ||
                     item.character == dtoi_pkg::CHAR_MINUS) begin
          negative_next = (item.character == dtoi_pkg::CHAR_MINUS);
          phase_next = PH_SIGNED;
        end else if (is_digit) begin
          take_digit = 1'b1;
          phase_next = PH_DIGITS;
        end else begin
          phase_next = PH_STOPPED;
        end
      end
      PH_SIGNED, PH_DIGITS: begin
        if (is_digit) begin
          take_digit = 1'b1;
          phase_next = PH_DIGITS;
        end else begin
          phase_next = PH_STOPPED;
        end
      end
      default: phase_next = PH_STOPPED;
    endcase
  end

  always_comb begin
    magnitude_next = magnitude;
    neg_magnitude_next = neg_magnitude;
    too_large_next = too_large;
    digit_seen_next = digit_seen || take_digit;
    if (take_digit && !too_large) begin
      if (overflow) begin
        too_large_next = 1'b1;
      end else begin
        magnitude_next = scaled[63:0];
        neg_magnitude_next = neg_scaled;
      end
    end
  end

  // result as seen after this character
  always_comb begin
    if (!digit_seen_next) begin
      result.value  = 64'd0;
      result.status = dtoi_pkg::ST_NAN;
    end else if (negative_next) begin
      if (too_large_next) begin
        result.value  = dtoi_pkg::NEG_LIMIT;
        result.status = dtoi_pkg::ST_SAT_LOW;
      end else begin
        result.value  = neg_magnitude_next;
        result.status = dtoi_pkg::ST_OK;
      end
    end else if (too_large_next || magnitude_next[63]) begin
      result.value  = dtoi_pkg::POS_LIMIT;
      result.status = dtoi_pkg::ST_SAT_HIGH;
    end else begin
      result.value  = magnitude_next;
      result.status = dtoi_pkg::ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || (step && item.last_char)) begin
      phase <= PH_SPACES;
      negative <= 1'b0;
      magnitude <= 64'd0;
      neg_magnitude <= 64'd0;
      too_large <= 1'b0;
      digit_seen <= 1'b0;
    end else if (step) begin
      phase <= phase_next;
      negative <= negative_next;
      magnitude <= magnitude_next;
      neg_magnitude <= neg_magnitude_next;
      too_large <= too_large_next;
      digit_seen <= digit_seen_next;
    end
  end

endmodule

/* design/dtoi_out_reg.sv */
// result register on the output stream
module dtoi_out_reg (
  input  logic              clk,
  input  logic              rst,
  input  logic              load,
  input  dtoi_pkg::result_t result,
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  output logic [63:0]       m_axis_tdata,   // [63:0] value
  output logic [1:0]        m_axis_tuser    // [1:0] status
);

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (load) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      m_axis_tdata <= result.value;
      m_axis_tuser <= result.status;
    end
  end

endmodule

/* design/dtoi_checker.sv */
// port-level checks for the converter, bound to the top level
`include "decimal_text_to_int64_saturating_top_macros.svh"

module dtoi_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [63:0] m_axis_tdata,
  input logic [1:0]  m_axis_tuser
);

  // a stalled result stays offered and unchanged
  `DTOI_ASSERT(a_out_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "result changed while stalled")
  // saturation and not-a-number codes come with their fixed values
  `DTOI_ASSERT(a_sat_high, m_axis_tvalid && m_axis_tuser == dtoi_pkg::ST_SAT_HIGH |-> m_axis_tdata == dtoi_pkg::POS_LIMIT, "high saturation value wrong")
  `DTOI_ASSERT(a_sat_low, m_axis_tvalid && m_axis_tuser == dtoi_pkg::ST_SAT_LOW |-> m_axis_tdata == dtoi_pkg::NEG_LIMIT, "low saturation value wrong")
  `DTOI_ASSERT(a_nan_zero, m_axis_tvalid && m_axis_tuser == dtoi_pkg::ST_NAN |-> m_axis_tdata == 64'd0, "not-a-number value not zero")
  // no result and an open input right after reset
  `DTOI_ASSERT_ALWAYS(a_rst_empty, rst |=> !m_axis_tvalid && s_axis_tready, "not empty after reset")

endmodule

bind decimal_text_to_int64_saturating_top dtoi_checker u_dtoi_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);
